### rtl/binary_confusion_metrics_assert.svh
// ============================================================================
// Assertion macros for the binary confusion metrics block
// Short forms for clocked assertions that are disabled while reset is high.
// ============================================================================
`ifndef BINARY_CONFUSION_METRICS_ASSERT_SVH
`define BINARY_CONFUSION_METRICS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCM_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge outside reset.
`define BCM_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

### rtl/bcm_pkg.sv
// ============================================================================
// bcm_pkg
// Shared constants, codes and controller/datapath types.
// ============================================================================
`default_nettype none

package bcm_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int OPCODE_W  = 2;
  localparam int WEIGHT_W  = 16;
  localparam int COUNT_O_W = 32;
  localparam int METRIC_W  = 17;
  localparam int MCC_W     = 18;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_STORE,
    S_PUBLISH
  } state_t;

  // Jobs run in this order for every item.
  typedef enum logic [3:0] {
    J_ACC,
    J_PREC,
    J_REC,
    J_SPEC,
    J_F1,
    J_RS,
    J_BAL,
    J_TPTN,
    J_FPFN,
    J_DEN1,
    J_DEN2,
    J_DEN3,
    J_MAG2,
    J_MDIV,
    J_ROOT
  } job_t;

  typedef enum logic [1:0] {
    U_MUL,
    U_DIV,
    U_SQRT
  } unit_t;

  typedef struct packed {
    logic update;
    logic load;
    logic step;
    logic store;
    logic publish;
    job_t job;
  } bcm_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } bcm_status_t;

  function automatic unit_t job_unit(input job_t job);
    unit_t u;
    case (job)
      J_RS, J_TPTN, J_FPFN, J_DEN1, J_DEN2, J_DEN3, J_MAG2: u = U_MUL;
      J_ROOT: u = U_SQRT;
      default: u = U_DIV;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### rtl/bcm_ifs.sv
// ============================================================================
// bcm channel interfaces
// Valid/ready channels for input items and result items.
// ============================================================================
`default_nettype none

interface bcm_in_if;
  import bcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                predicted;
  logic                actual_positive;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, opcode, predicted, actual_positive, weight, input ready);
  modport sink   (input valid, opcode, predicted, actual_positive, weight, output ready);
endinterface

interface bcm_out_if;
  import bcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COUNT_O_W-1:0]     true_pos;
  logic [COUNT_O_W-1:0]     false_pos;
  logic [COUNT_O_W-1:0]     false_neg;
  logic [COUNT_O_W-1:0]     true_neg;
  logic [METRIC_W-1:0]      accuracy;
  logic [METRIC_W-1:0]      precision_q;
  logic [METRIC_W-1:0]      recall_q;
  logic [METRIC_W-1:0]      specificity_q;
  logic [METRIC_W-1:0]      f1_q;
  logic [METRIC_W-1:0]      balanced_q;
  logic signed [MCC_W-1:0]  matthews_q;

  modport source (output valid, true_pos, false_pos, false_neg, true_neg, accuracy,
                  precision_q, recall_q, specificity_q, f1_q, balanced_q, matthews_q,
                  input ready);
  modport sink   (input valid, true_pos, false_pos, false_neg, true_neg, accuracy,
                  precision_q, recall_q, specificity_q, f1_q, balanced_q, matthews_q,
                  output ready);
endinterface

`default_nettype wire

### rtl/bcm_ctrl.sv
// ============================================================================
// bcm_ctrl
// Sequencer that walks the datapath through its job list for each item.
// ============================================================================
`default_nettype none

module bcm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output bcm_pkg::bcm_cmd_t    cmd,
  input  bcm_pkg::bcm_status_t status
);
  import bcm_pkg::*;

  state_t state, state_next;
  job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= J_ACC;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOAD;
          job_next   = J_ACC;
        end
      end
      S_LOAD: state_next = S_RUN;
      S_RUN: begin
        if (status.done) state_next = S_STORE;
      end
      S_STORE: begin
        if (job == J_ROOT) begin
          state_next = S_PUBLISH;
        end else begin
          state_next = S_LOAD;
          job_next   = job_t'(job + 4'd1);
        end
      end
      S_PUBLISH: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.job     = job;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.update = in_valid;
      end
      S_LOAD:    cmd.load    = 1'b1;
      S_RUN:     cmd.step    = !status.done;
      S_STORE:   cmd.store   = 1'b1;
      S_PUBLISH: cmd.publish = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bcm_dpath.sv
// ============================================================================
// bcm_dpath
// Counters, shift-add multiplier, restoring divider, square root and the
// result register.
// ============================================================================
`default_nettype none

module bcm_dpath #(
  parameter int COUNT_WIDTH = bcm_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = bcm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bcm_pkg::bcm_cmd_t             cmd,
  output bcm_pkg::bcm_status_t          status,
  input  logic [bcm_pkg::OPCODE_W-1:0]  opcode,
  input  logic                          predicted,
  input  logic                          actual_positive,
  input  logic [bcm_pkg::WEIGHT_W-1:0]  weight,
  bcm_out_if.source                     results
);
  import bcm_pkg::*;

  localparam int CW  = COUNT_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int SW  = CW + WEIGHT_W + 1;
  localparam int EW  = CW + 3;
  localparam int PW  = 4 * CW + 4;
  localparam int RW  = 4 * CW + 6;
  localparam int MW  = (2 * CW > F + 1) ? 2 * CW : F + 1;
  localparam int QW  = 2 * F + 1;
  localparam int LW  = 2 * F + 2;
  localparam int MQ  = F + 1;
  localparam int SRW = F + 4;
  localparam int DCW = $clog2(LW + 1);
  localparam int SCW = $clog2(F + 2);
  localparam int BAL_THR = (10 * (2 ** F) + 999999) / 1000000;
  localparam logic [CW-1:0] CMAX = '1;

  unit_t unit;
  assign unit = job_unit(cmd.job);

  // Counters
  logic [CW-1:0] tp_count, fp_count, fn_count, tn_count;
  logic [CW-1:0] cur, add_val, sub_val;
  logic [SW-1:0] add_sum;

  always_comb begin
    case ({predicted, actual_positive})
      2'b11:   cur = tp_count;
      2'b10:   cur = fp_count;
      2'b01:   cur = fn_count;
      default: cur = tn_count;
    endcase
    add_sum = SW'(cur) + SW'(weight);
    add_val = (add_sum > SW'(CMAX)) ? CMAX : add_sum[CW-1:0];
    sub_val = (SW'(cur) >= SW'(weight)) ? CW'(SW'(cur) - SW'(weight)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tp_count <= '0;
      fp_count <= '0;
      fn_count <= '0;
      tn_count <= '0;
    end else if (cmd.update) begin
      case (opcode_t'(opcode))
        OP_ADD, OP_REMOVE: begin
          case ({predicted, actual_positive})
            2'b11:   tp_count <= (opcode_t'(opcode) == OP_ADD) ? add_val : sub_val;
            2'b10:   fp_count <= (opcode_t'(opcode) == OP_ADD) ? add_val : sub_val;
            2'b01:   fn_count <= (opcode_t'(opcode) == OP_ADD) ? add_val : sub_val;
            default: tn_count <= (opcode_t'(opcode) == OP_ADD) ? add_val : sub_val;
          endcase
        end
        OP_CLEAR: begin
          tp_count <= '0;
          fp_count <= '0;
          fn_count <= '0;
          tn_count <= '0;
        end
        default: begin
          tp_count <= tp_count;
        end
      endcase
    end
  end

  logic [EW-1:0] tp_e, fp_e, fn_e, tn_e;
  assign tp_e = EW'(tp_count);
  assign fp_e = EW'(fp_count);
  assign fn_e = EW'(fn_count);
  assign tn_e = EW'(tn_count);

  // Intermediate results
  logic [MQ-1:0]        acc_r, prec_r, rec_r, spec_r, f1_r, bal_r;
  logic [QW-1:0]        prod_rs;
  logic [2*CW-1:0]      a_reg, b_reg, mag;
  logic                 mneg;
  logic [PW-1:0]        d_reg;
  logic [4*CW-1:0]      m2;
  logic signed [F+1:0]  mcc_r;
  logic                 bal_low;

  assign mneg    = b_reg > a_reg;
  assign mag     = mneg ? (b_reg - a_reg) : (a_reg - b_reg);
  assign bal_low = ((F + 2)'(rec_r) + (F + 2)'(spec_r)) < (F + 2)'(BAL_THR);

  // Operand selection
  logic [RW-1:0]  dh, dd;
  logic [LW-1:0]  dl;
  logic [DCW-1:0] dlen;
  logic [PW-1:0]  ma;
  logic [MW-1:0]  mbv;

  always_comb begin
    dh   = '0;
    dd   = '0;
    dl   = '0;
    dlen = DCW'(F);
    ma   = '0;
    mbv  = '0;
    case (cmd.job)
      J_ACC: begin
        dh = RW'(tp_e + tn_e);
        dd = RW'(tp_e + fp_e + fn_e + tn_e);
      end
      J_PREC: begin
        dh = RW'(tp_e);
        dd = RW'(tp_e + fp_e);
      end
      J_REC: begin
        dh = RW'(tp_e);
        dd = RW'(tp_e + fn_e);
      end
      J_SPEC: begin
        dh = RW'(tn_e);
        dd = RW'(tn_e + fp_e);
      end
      J_F1: begin
        dh = RW'(tp_e << 1);
        dd = RW'((tp_e << 1) + fp_e + fn_e);
      end
      J_BAL: begin
        dl   = {prod_rs, 1'b0};
        dd   = RW'(rec_r) + RW'(spec_r);
        dlen = DCW'(LW);
      end
      J_MDIV: begin
        dh   = RW'(m2);
        dd   = RW'(d_reg);
        dlen = DCW'(2 * F);
      end
      J_RS: begin
        ma  = PW'(rec_r);
        mbv = MW'(spec_r);
      end
      J_TPTN: begin
        ma  = PW'(tp_count);
        mbv = MW'(tn_count);
      end
      J_FPFN: begin
        ma  = PW'(fp_count);
        mbv = MW'(fn_count);
      end
      J_DEN1: begin
        ma  = PW'(tp_e + fn_e);
        mbv = MW'(fp_e + tn_e);
      end
      J_DEN2: begin
        ma  = d_reg;
        mbv = MW'(tp_e + fp_e);
      end
      J_DEN3: begin
        ma  = d_reg;
        mbv = MW'(fn_e + tn_e);
      end
      J_MAG2: begin
        ma  = PW'(mag);
        mbv = MW'(mag);
      end
      default: begin
        dh = '0;
      end
    endcase
  end

  // Shift-add multiplier, one multiplier bit per cycle; ends when no bits remain.
  logic [PW-1:0] macc, ma_r;
  logic [MW-1:0] mb_r;

  // Restoring divider. The first step compares without shifting, so the
  // quotient is floor((h * 2^len + l) / d).
  logic [RW-1:0]  rem, dvs, rshift;
  logic [LW-1:0]  dshl;
  logic [QW-1:0]  dq;
  logic [DCW-1:0] dcnt;
  logic           dfirst, dz, dge;

  assign rshift = dfirst ? rem : {rem[RW-2:0], dshl[LW-1]};
  assign dge    = rshift >= dvs;

  // Digit-by-digit square root, two radicand bits per cycle.
  logic [LW-1:0]  rad;
  logic [SRW-1:0] srem, r2, trial;
  logic [MQ-1:0]  root;
  logic [SCW-1:0] scnt;
  logic           sge;

  assign r2    = {srem[SRW-3:0], rad[LW-1:LW-2]};
  assign trial = SRW'({root, 2'b01});
  assign sge   = r2 >= trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (unit)
        U_MUL: begin
          macc <= '0;
          ma_r <= ma;
          mb_r <= mbv;
        end
        U_DIV: begin
          rem    <= dh;
          dvs    <= dd;
          dshl   <= dl;
          dq     <= '0;
          dcnt   <= dlen;
          dfirst <= 1'b1;
          dz     <= (dd == '0);
        end
        default: begin
          rad  <= LW'(dq);
          srem <= '0;
          root <= '0;
          scnt <= SCW'(F + 1);
        end
      endcase
    end else if (cmd.step) begin
      case (unit)
        U_MUL: begin
          if (mb_r[0]) macc <= macc + ma_r;
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
        end
        U_DIV: begin
          rem    <= dge ? (rshift - dvs) : rshift;
          dq     <= {dq[QW-2:0], dge};
          dfirst <= 1'b0;
          if (!dfirst) begin
            dshl <= dshl << 1;
            dcnt <= dcnt - DCW'(1);
          end
        end
        default: begin
          rad  <= rad << 2;
          srem <= sge ? (r2 - trial) : r2;
          root <= {root[MQ-2:0], sge};
          scnt <= scnt - SCW'(1);
        end
      endcase
    end
  end

  // Output register: the next item may start while this result waits.
  always_comb begin
    status.out_free = !results.valid || results.ready;
    case (unit)
      U_MUL:   status.done = (mb_r == '0);
      U_DIV:   status.done = !dfirst && (dcnt == '0);
      default: status.done = (scnt == '0);
    endcase
  end

  // Store the finished job's result.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.job)
        J_ACC:  acc_r  <= dz ? '0 : dq[MQ-1:0];
        J_PREC: prec_r <= dz ? '0 : dq[MQ-1:0];
        J_REC:  rec_r  <= dz ? '0 : dq[MQ-1:0];
        J_SPEC: spec_r <= dz ? '0 : dq[MQ-1:0];
        J_F1:   f1_r   <= dz ? (MQ'(1) << F) : dq[MQ-1:0];
        J_RS:   prod_rs <= macc[QW-1:0];
        J_BAL:  bal_r  <= bal_low ? '0 : dq[MQ-1:0];
        J_TPTN: a_reg  <= macc[2*CW-1:0];
        J_FPFN: b_reg  <= macc[2*CW-1:0];
        J_DEN1, J_DEN2, J_DEN3: d_reg <= macc;
        J_MAG2: m2     <= macc[4*CW-1:0];
        J_ROOT: begin
          if (d_reg == '0) mcc_r <= '0;
          else if (mneg)   mcc_r <= -$signed({1'b0, root});
          else             mcc_r <= $signed({1'b0, root});
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.publish) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      results.true_pos      <= COUNT_O_W'(tp_count);
      results.false_pos     <= COUNT_O_W'(fp_count);
      results.false_neg     <= COUNT_O_W'(fn_count);
      results.true_neg      <= COUNT_O_W'(tn_count);
      results.accuracy      <= METRIC_W'(acc_r);
      results.precision_q   <= METRIC_W'(prec_r);
      results.recall_q      <= METRIC_W'(rec_r);
      results.specificity_q <= METRIC_W'(spec_r);
      results.f1_q          <= METRIC_W'(f1_r);
      results.balanced_q    <= METRIC_W'(bal_r);
      results.matthews_q    <= MCC_W'(mcc_r);
    end
  end

endmodule

`default_nettype wire

### rtl/binary_confusion_metrics.sv
// ============================================================================
// binary_confusion_metrics
// Confusion matrix counters with fixed-point quality metrics per item.
// ============================================================================
//
//   Channel   Role   Carries
//   items     sink   opcode, predicted, actual_positive, weight
//   results   source four counts, six unsigned metrics, Matthews correlation
//
// Each item runs through the shift-add multiplier and restoring divider, which
// handle one bit per cycle, and the square root, all shared by every metric;
// a product finishes early when its multiplier operand is short.
// Reset is synchronous and clears the counters and the result channel.
// A finished result waits in an output register; the next item is accepted
// while it waits, and only the following publish stalls on a full register.
`default_nettype none
`include "binary_confusion_metrics_assert.svh"

module binary_confusion_metrics #(
  parameter int COUNT_WIDTH = bcm_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = bcm_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bcm_in_if.sink    items,
  bcm_out_if.source results
);
  import bcm_pkg::*;

  bcm_cmd_t    cmd;
  bcm_status_t status;

  bcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .cmd      (cmd),
    .status   (status)
  );

  bcm_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .opcode          (items.opcode),
    .predicted       (items.predicted),
    .actual_positive (items.actual_positive),
    .weight          (items.weight),
    .results         (results)
  );

  `BCM_ASSERT_NEXT(a_busy_after_accept, items.valid && items.ready, !items.ready, "item accepted while busy")
  `BCM_ASSERT_NEXT(a_publish_shows, cmd.publish, results.valid, "published result not visible")
  `BCM_ASSERT_SAME(a_store_when_done, cmd.store, status.done, "job stored before its unit finished")
  `BCM_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.update, cmd.load, cmd.step, cmd.store, cmd.publish}), "more than one command issued")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics testbench
// Drives add, remove, clear and query transactions with random idling on both
// channels, predicts every result in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bcm_pkg::*;

  typedef struct {
    bit [31:0]        tp, fp, fn, tn;
    bit [16:0]        acc, prec, rec, spec, f1, bal;
    bit signed [17:0] mcc;
  } metrics_t;

  class metrics_scoreboard;
    bit [63:0] tp, fp, fn, tn;
    metrics_t  pending[$];
    int        errors;

    function new();
      tp = 0; fp = 0; fn = 0; tn = 0;
      errors = 0;
    endfunction

    function bit [63:0] ratio(bit [63:0] n, bit [63:0] d);
      return (d == 0) ? 64'd0 : (n << 16) / d;
    endfunction

    function bit signed [17:0] correlation();
      bit [63:0]  pos, neg, ppos, pneg, a, b, mag, lo, hi, mid;
      bit [255:0] den, rhs, lhs;
      pos = tp + fn; neg = fp + tn; ppos = tp + fp; pneg = fn + tn;
      if (pos == 0 || neg == 0 || ppos == 0 || pneg == 0) return 18'sd0;
      a = tp * tn;
      b = fp * fn;
      mag = (a >= b) ? a - b : b - a;
      den = 256'(pos) * 256'(neg) * 256'(ppos) * 256'(pneg);
      rhs = (256'(mag) * 256'(mag)) << 32;
      lo = 0;
      hi = 64'd65536;
      // Largest root estimate whose square times the denominator stays in bound.
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 256'(mid * mid) * den;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (b > a) ? -$signed(18'(lo)) : $signed(18'(lo));
    endfunction

    function void note_item(opcode_t op, bit pred, bit act, bit [15:0] w);
      bit [63:0] sel, rec, spec, sum, errs, tmp;
      metrics_t  m;
      sel = pred ? (act ? tp : fp) : (act ? fn : tn);
      case (op)
        OP_ADD:    sel = (sel + w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sel + w;
        OP_REMOVE: sel = (sel >= w) ? sel - w : 64'd0;
        default:   ;
      endcase
      if (op == OP_ADD || op == OP_REMOVE) begin
        if (pred && act) tp = sel;
        else if (pred) fp = sel;
        else if (act) fn = sel;
        else tn = sel;
      end else if (op == OP_CLEAR) begin
        tp = 0; fp = 0; fn = 0; tn = 0;
      end
      rec = ratio(tp, tp + fn);
      spec = ratio(tn, tn + fp);
      sum = rec + spec;
      errs = 2 * tp + fp + fn;
      m.tp = tp[31:0]; m.fp = fp[31:0]; m.fn = fn[31:0]; m.tn = tn[31:0];
      tmp = ratio(tp + tn, tp + fp + fn + tn);
      m.acc = tmp[16:0];
      tmp = ratio(tp, tp + fp);
      m.prec = tmp[16:0];
      m.rec = rec[16:0];
      m.spec = spec[16:0];
      tmp = (errs == 0) ? 64'h10000 : ratio(2 * tp, errs);
      m.f1 = tmp[16:0];
      tmp = (sum == 0) ? 64'd0 : (2 * rec * spec) / sum;
      m.bal = tmp[16:0];
      m.mcc = correlation();
      pending.push_back(m);
    endfunction

    function void report(string name, longint exp, longint act);
      if (exp != act) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_result(metrics_t got);
      metrics_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result transaction: expected none actual tp=%0d",
                 $time, got.tp);
        return;
      end
      e = pending.pop_front();
      report("true_pos", e.tp, got.tp);
      report("false_pos", e.fp, got.fp);
      report("false_neg", e.fn, got.fn);
      report("true_neg", e.tn, got.tn);
      report("accuracy", e.acc, got.acc);
      report("precision_q", e.prec, got.prec);
      report("recall_q", e.rec, got.rec);
      report("specificity_q", e.spec, got.spec);
      report("f1_q", e.f1, got.f1);
      report("balanced_q", e.bal, got.bal);
      report("matthews_q", e.mcc, got.mcc);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   items_done = 1'b0;
  int   idle_cycles = 0;
  int   result_count = 0;
  metrics_scoreboard board = new();

  bcm_in_if  items_if();
  bcm_out_if results_if();

  binary_confusion_metrics dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always #1 clk = ~clk;

  // Draws an idle gap, with stretches of back-to-back transactions.
  function automatic int draw_gap(int n);
    return ((n / 64) % 3 == 1) ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_item(opcode_t op, bit pred, bit act, bit [15:0] w, int n);
    int gap;
    gap = draw_gap(n);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.opcode <= op;
    items_if.predicted <= pred;
    items_if.actual_positive <= act;
    items_if.weight <= w;
    do @(posedge clk); while (!items_if.ready);
    board.note_item(op, pred, act, w);
  endtask

  task automatic send_random(int n);
    int        pick;
    opcode_t   op;
    bit [15:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 62) op = OP_ADD;
    else if (pick < 88) op = OP_REMOVE;
    else if (pick < 91) op = OP_CLEAR;
    else op = OP_QUERY;
    pick = $urandom_range(0, 9);
    if (pick < 5) w = 16'($urandom_range(0, 65535));
    else if (pick < 8) w = 16'($urandom_range(0, 15));
    else w = 16'($urandom_range(0, 255));
    send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w, n);
  endtask

  initial begin
    items_if.valid = 1'b0;
    items_if.opcode = OP_QUERY;
    items_if.predicted = 1'b0;
    items_if.actual_positive = 1'b0;
    items_if.weight = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(OP_QUERY, 1, 1, 16'hFFFF, 0);
    send_item(OP_ADD, 1, 1, 16'hFFFF, 1);
    send_item(OP_ADD, 1, 0, 16'd1, 2);
    send_item(OP_ADD, 0, 1, 16'd0, 3);
    send_item(OP_ADD, 0, 1, 16'd300, 4);
    send_item(OP_ADD, 0, 0, 16'hFFFF, 5);
    send_item(OP_QUERY, 0, 0, 16'd0, 6);
    send_item(OP_REMOVE, 1, 0, 16'hFFFF, 7);
    send_item(OP_REMOVE, 0, 0, 16'd1, 8);
    send_item(OP_REMOVE, 1, 1, 16'd0, 9);
    send_item(OP_ADD, 1, 0, 16'd40000, 10);
    send_item(OP_ADD, 0, 1, 16'hFFFF, 11);
    send_item(OP_CLEAR, 1, 0, 16'h1234, 12);
    send_item(OP_QUERY, 0, 1, 16'hFFFF, 13);
    send_item(OP_ADD, 1, 1, 16'd5, 14);
    send_item(OP_ADD, 0, 0, 16'd7, 15);
    send_item(OP_REMOVE, 1, 1, 16'd5, 16);
    send_item(OP_ADD, 1, 0, 16'd3, 17);
    send_item(OP_ADD, 0, 1, 16'd9, 18);
    send_item(OP_REMOVE, 0, 0, 16'hFFFF, 19);
    send_item(OP_CLEAR, 0, 0, 16'd0, 20);
    send_item(OP_ADD, 0, 0, 16'd1, 21);
    for (int i = 22; i < 1100; i++) send_random(i);
    items_if.valid <= 1'b0;
    items_done = 1'b1;
  end

  // Result side, with one long hold-off so that the block backs up.
  initial begin
    metrics_t got;
    int       gap;
    results_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (result_count == 300) begin
        results_if.ready <= 1'b0;
        repeat (2500) @(posedge clk);
      end else begin
        gap = draw_gap(result_count + 32);
        if (gap > 0) begin
          results_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      got.tp = results_if.true_pos;
      got.fp = results_if.false_pos;
      got.fn = results_if.false_neg;
      got.tn = results_if.true_neg;
      got.acc = results_if.accuracy;
      got.prec = results_if.precision_q;
      got.rec = results_if.recall_q;
      got.spec = results_if.specificity_q;
      got.f1 = results_if.f1_q;
      got.bal = results_if.balanced_q;
      got.mcc = results_if.matthews_q;
      board.check_result(got);
      result_count++;
    end
  end

  always @(posedge clk) begin
    if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 10000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (items_done);
    wait (board.pending.size() == 0);
    repeat (600) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### binary_confusion_metrics.f
+incdir+rtl
rtl/bcm_pkg.sv
rtl/bcm_ifs.sv
rtl/bcm_ctrl.sv
rtl/bcm_dpath.sv
rtl/binary_confusion_metrics.sv
sim/testbench.sv
